// File: rtl/euler_integrator_differentiator_bank_unit_assert.svh
// Assertion macros shared by the integrator/differentiator bank RTL.
// Expects signals named clk and rst in the module that uses them.
`ifndef EULER_INTEGRATOR_DIFFERENTIATOR_BANK_UNIT_ASSERT_SVH
`define EULER_INTEGRATOR_DIFFERENTIATOR_BANK_UNIT_ASSERT_SVH

// Check cons in the same cycle as ante.
`define EIDB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("eidb: same-cycle check failed");

// Check cons in the cycle after ante.
`define EIDB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("eidb: next-cycle check failed");

`endif

// File: rtl/eidb_pkg.sv
// Package for the integrator/differentiator bank: defaults, codes, fixed-point
// limits and the divider request/status structs. No dependencies.
package eidb_pkg;

  localparam int EIDB_SLOT_COUNT    = 64;
  localparam int EIDB_FRACTION_BITS = 16;

  // Slot field is 6 bits wide, so 64 codes can arrive.
  localparam int SLOT_FIELD_W = 6;
  localparam int SLOT_CODES   = 1 << SLOT_FIELD_W;

  localparam logic [31:0] TIMESTEP_RESET = 32'd655;

  localparam logic CMD_INTEGRATE     = 1'b0;
  localparam logic CMD_DIFFERENTIATE = 1'b1;

  // Quotient bits produced by the divider.
  localparam int DIV_STEPS = 32;

  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic        start;
    logic [31:0] rem;      // upper dividend bits, already below divisor
    logic [31:0] low;      // lower 32 dividend bits
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: rtl/eidb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module eidb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/eidb_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, 32-bit quotient.
// Depends on eidb_pkg (div_req_t, div_stat_t, DIV_STEPS).
module eidb_div
  import eidb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  div_req_t    req,
  output div_stat_t   stat,
  output logic [31:0] quotient
);

  localparam int CW = $clog2(DIV_STEPS);

  logic [31:0]   rem;
  logic [31:0]   q;
  logic [31:0]   divisor;
  logic [CW-1:0] count;
  logic          busy;
  logic          done;

  logic [32:0] trial;
  logic        fits;
  logic [31:0] rem_next;

  // Remainder stays below the divisor, so the trial value fits 33 bits and
  // the new remainder fits 32.
  always_comb begin
    trial    = {rem, q[31]};
    fits     = trial >= {1'b0, divisor};
    rem_next = fits ? 32'(trial - {1'b0, divisor}) : trial[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem     <= req.rem;
        q       <= req.low;
        divisor <= req.divisor;
        count   <= '0;
        busy    <= 1'b1;
      end else if (busy) begin
        rem <= rem_next;
        q   <= {q[30:0], fits};
        if (count == CW'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count + 1'b1;
        end
      end
    end
  end

  assign stat     = '{busy: busy, done: done};
  assign quotient = q;

endmodule

// File: rtl/euler_integrator_differentiator_bank_unit.sv
// Top level of the Euler integrator / backward-difference differentiator bank.
// Depends on eidb_pkg, eidb_ram, eidb_div and the assertion macro header.
//
//   channel   direction  handshake              payload
//   in        sink       in_valid / in_ready    command, slot, value, initial_value, hold
//   out       source     out_valid / out_ready  result, saturated
//   cfg       sink       cfg_we                 cfg_data (timestep)
//
// One item at a time, from the accept cycle up to the output load: integrate reads,
// multiplies (33x32), adds and clips, then loads; hold returns the stored value;
// differentiate uses the restoring divider, skipped on zero difference or early overflow.
// Reset clears the used marks of every slot at once; there is no clearing pass.
// The output register lets a finished result wait while the next item is taken;
// a stalled output holds the finished result, and the engine waits until it drains.

`include "euler_integrator_differentiator_bank_unit_assert.svh"

module euler_integrator_differentiator_bank_unit
  import eidb_pkg::*;
#(
  parameter int SLOT_COUNT    = EIDB_SLOT_COUNT,
  parameter int FRACTION_BITS = EIDB_FRACTION_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [31:0]               cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      command,
  input  logic [SLOT_FIELD_W-1:0]   slot,
  input  logic signed [31:0]        value,
  input  logic signed [31:0]        initial_value,
  input  logic                      hold,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [31:0]        result,
  output logic                      saturated
);

  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  // Magnitude of (diff << FRACTION_BITS): diff spans 33 bits.
  localparam int NB = 33 + FRACTION_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_CALC = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_PUT  = 3'd4;

  // Fold every slot code into the bank; a constant table, built at elaboration.
  function automatic logic [SLOT_CODES-1:0][AW-1:0] build_wrap();
    logic [SLOT_CODES-1:0][AW-1:0] tbl;
    int v;
    for (int i = 0; i < SLOT_CODES; i++) begin
      v = i;
      while (v >= SLOT_COUNT) begin
        v = v - SLOT_COUNT;
      end
      tbl[i] = AW'(v);
    end
    return tbl;
  endfunction

  localparam logic [SLOT_CODES-1:0][AW-1:0] SLOT_WRAP = build_wrap();

  logic [2:0] state;
  logic [2:0] state_next;

  logic [31:0] timestep;

  // Item registers, held for the whole item.
  logic               cmd_r;
  logic [AW-1:0]      slot_r;
  logic signed [31:0] value_r;
  logic signed [31:0] init_r;
  logic               hold_r;

  logic [SLOT_COUNT-1:0] int_used;
  logic [SLOT_COUNT-1:0] der_used;

  // Working registers.
  logic signed [31:0] base_r;
  logic signed [63:0] prod_r;
  logic signed [32:0] diff_r;
  logic signed [31:0] res_p;
  logic               sat_p;

  // Memories: integral sums, and {previous sample, last derivative}.
  logic        accept;
  logic        int_we;
  logic [31:0] int_wdata;
  logic [31:0] int_rdata;
  logic        der_we;
  logic [63:0] der_wdata;
  logic [63:0] der_rdata;

  div_req_t    div_req;
  div_stat_t   div_stat;
  logic [31:0] div_q;

  // Datapath values.
  logic signed [31:0] int_cur;
  logic signed [31:0] prev_cur;
  logic signed [31:0] last_cur;
  logic signed [32:0] ts_s;
  logic signed [64:0] prod_full;
  logic signed [63:0] prod_sh;
  logic signed [63:0] sum;
  logic signed [31:0] sum_clip;
  logic               sum_sat;
  logic [32:0]        mag;
  logic [NB-1:0]      num_mag;
  logic [31:0]        num_hi;
  logic               pre_sat;
  logic signed [31:0] div_res;
  logic               div_sat;
  logic               res_load;
  logic signed [31:0] res_next;
  logic               sat_next;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);

  eidb_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_int_ram (
    .clk   (clk),
    .we    (int_we),
    .waddr (slot_r),
    .wdata (int_wdata),
    .re    (accept),
    .raddr (SLOT_WRAP[slot]),
    .rdata (int_rdata)
  );

  eidb_ram #(.WIDTH(64), .DEPTH(SLOT_COUNT)) u_der_ram (
    .clk   (clk),
    .we    (der_we),
    .waddr (slot_r),
    .wdata (der_wdata),
    .re    (accept),
    .raddr (SLOT_WRAP[slot]),
    .rdata (der_rdata)
  );

  eidb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // Stored state of the slot, or its first-touch value. A used differentiator
  // slot always has a valid last derivative: first touch writes zero with it.
  always_comb begin
    int_cur  = int_used[slot_r] ? $signed(int_rdata) : init_r;
    prev_cur = der_used[slot_r] ? $signed(der_rdata[63:32]) : value_r;
    last_cur = der_used[slot_r] ? $signed(der_rdata[31:0]) : 32'sd0;
    ts_s     = $signed({1'b0, timestep});
    prod_full = ts_s * value_r;
  end

  // Integrate: floor shift, accumulate, clip.
  always_comb begin
    prod_sh = prod_r >>> FRACTION_BITS;
    sum     = prod_sh + 64'(base_r);
    if (sum > 64'(Q_MAX)) begin
      sum_clip = Q_MAX;
      sum_sat  = 1'b1;
    end else if (sum < 64'(Q_MIN)) begin
      sum_clip = Q_MIN;
      sum_sat  = 1'b1;
    end else begin
      sum_clip = sum[31:0];
      sum_sat  = 1'b0;
    end
  end

  // Differentiate: magnitude of the scaled difference. If its upper bits
  // already reach the timestep, the quotient cannot fit 32 bits: saturate
  // without dividing. A zero timestep lands here too.
  always_comb begin
    mag     = diff_r[32] ? 33'(-diff_r) : 33'(diff_r);
    num_mag = NB'(mag) << FRACTION_BITS;
    num_hi  = 32'(num_mag >> 32);
    pre_sat = num_hi >= timestep;
  end

  // Apply sign to the unsigned quotient and clip.
  always_comb begin
    if (diff_r[32]) begin
      div_sat = div_q > 32'h8000_0000;
      div_res = div_sat ? Q_MIN : $signed(32'(32'd0 - div_q));
    end else begin
      div_sat = div_q[31];
      div_res = div_sat ? Q_MAX : $signed(div_q);
    end
  end

  // Sequencer, memory writes and divider start.
  always_comb begin
    state_next = state;
    int_we     = 1'b0;
    int_wdata  = int_cur;
    der_we     = 1'b0;
    der_wdata  = {prev_cur, last_cur};
    res_load   = 1'b0;
    res_next   = 32'sd0;
    sat_next   = 1'b0;
    div_req    = '{start: 1'b0, rem: num_hi, low: num_mag[31:0], divisor: timestep};
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (hold_r) begin
          // Return the stored value; the write-back captures a first touch and rewrites a used slot unchanged.
          res_load = 1'b1;
          if (cmd_r == CMD_INTEGRATE) begin
            int_we   = 1'b1;
            res_next = int_cur;
          end else begin
            der_we   = 1'b1;
            res_next = last_cur;
          end
          state_next = S_PUT;
        end else begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        if (cmd_r == CMD_INTEGRATE) begin
          int_we     = 1'b1;
          int_wdata  = sum_clip;
          res_load   = 1'b1;
          res_next   = sum_clip;
          sat_next   = sum_sat;
          state_next = S_PUT;
        end else if (diff_r == 33'sd0) begin
          der_we     = 1'b1;
          der_wdata  = {value_r, 32'd0};
          res_load   = 1'b1;
          state_next = S_PUT;
        end else if (pre_sat) begin
          der_we     = 1'b1;
          res_next   = diff_r[32] ? Q_MIN : Q_MAX;
          der_wdata  = {value_r, res_next};
          res_load   = 1'b1;
          sat_next   = 1'b1;
          state_next = S_PUT;
        end else begin
          div_req.start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          der_we     = 1'b1;
          der_wdata  = {value_r, div_res};
          res_load   = 1'b1;
          res_next   = div_res;
          sat_next   = div_sat;
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      timestep  <= TIMESTEP_RESET;
      int_used  <= '0;
      der_used  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        timestep <= cfg_data;
      end
      // Mark the slot used on first touch, hold or not.
      if (state == S_EXEC) begin
        if (cmd_r == CMD_INTEGRATE) begin
          int_used[slot_r] <= 1'b1;
        end else begin
          der_used[slot_r] <= 1'b1;
        end
      end
      // Load the output register when it drains; otherwise drop valid on take.
      if (state == S_PUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= command;
      slot_r  <= SLOT_WRAP[slot];
      value_r <= value;
      init_r  <= initial_value;
      hold_r  <= hold;
    end
    if (state == S_EXEC) begin
      base_r <= int_cur;
      prod_r <= prod_full[63:0];
      diff_r <= 33'(value_r) - 33'(prev_cur);
    end
    if (res_load) begin
      res_p <= res_next;
      sat_p <= sat_next;
    end
    if (state == S_PUT && (!out_valid || out_ready)) begin
      result    <= res_p;
      saturated <= sat_p;
    end
  end

  `EIDB_ASSERT_NEXT(a_accept_to_exec, accept, state == S_EXEC)
  `EIDB_ASSERT_NOW(a_write_in_work, int_we || der_we,
                   state == S_EXEC || state == S_CALC || state == S_DIV)
  `EIDB_ASSERT_NOW(a_div_done_in_div, div_stat.done, state == S_DIV)
  `EIDB_ASSERT_NOW(a_sat_is_extreme, out_valid && saturated,
                   result == Q_MAX || result == Q_MIN)

endmodule
